// File: design/indexed_insert_delete_list_top_assert.svh
// Assertion macros for the indexed insert/delete list
`ifndef INDEXED_INSERT_DELETE_LIST_TOP_ASSERT_SVH
`define INDEXED_INSERT_DELETE_LIST_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define IDLL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("idll assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define IDLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("idll assertion failed");

`endif

// File: design/idll_pkg.sv
// Types and constants shared by the indexed insert/delete list
package idll_pkg;

  // compare width for positions and lengths (holds 0..127)
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LIST   = 2'd2,
    ACT_RESIZE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_SIZE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_TRIM,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] arg;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

endpackage

// File: design/idll_in_if.sv
// Request channel of the indexed insert/delete list
interface idll_in_if;
  import idll_pkg::*;

  logic               valid;
  logic               ready;
  action_t            action;
  logic [5:0]         position;
  logic signed [31:0] item_value;
  logic [5:0]         new_length;

  modport source (output valid, action, position, item_value, new_length, input ready);
  modport sink   (input valid, action, position, item_value, new_length, output ready);
endinterface

// File: design/idll_out_if.sv
// Result channel of the indexed insert/delete list
interface idll_out_if;
  import idll_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [5:0]         slot;
  logic signed [31:0] data;
  logic               last;

  modport source (output valid, status, slot, data, last, input ready);
  modport sink   (input valid, status, slot, data, last, output ready);
endinterface

// File: design/idll_cell.sv
// One list cell: holds one entry and trades it with its neighbors
module idll_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  idll_pkg::cell_cmd_t    cmd,
  input  logic [VALUE_WIDTH-1:0] ins_value,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic [VALUE_WIDTH-1:0] wrap_value,
  output logic [VALUE_WIDTH-1:0] value
);
  import idll_pkg::*;

  localparam logic [CNT_W-1:0] ME = CNT_W'(INDEX);

  logic [VALUE_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    unique case (cmd.op)
      CELL_INSERT: begin
        if (ME == cmd.arg) begin
          value_next = ins_value;
        end else if (ME > cmd.arg) begin
          value_next = left_value;
        end
      end
      CELL_DELETE: begin
        if (ME >= cmd.arg) begin
          value_next = right_value;
        end
      end
      CELL_TRIM: begin
        if (ME >= cmd.arg) begin
          value_next = '0;
        end
      end
      CELL_ROTATE: begin
        if (ME == cmd.arg) begin
          value_next = wrap_value;
        end else if (ME < cmd.arg) begin
          value_next = right_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      value <= value_next;
    end
  end
endmodule

// File: design/indexed_insert_delete_list_top.sv
// Indexed insert/delete list: control, output register and the cell chain
//
// Requests arrive on req (action, position, item_value, new_length) and
// results leave on rsp (status, slot, data, last); both are valid/ready.
// Insert, delete and resize update the cell chain in the cycle the request
// is taken, and their single result is registered for the next cycle.
// A list request of a non-empty list emits one result per cycle while rsp
// is not stalled, entry 0 first, by rotating the first length cells down
// by one per result; after length steps the chain is back in order.
// A list holds req.ready low until its last result is loaded.
// Errors report a status and leave the list unchanged.
// A stalled rsp holds its result and pauses the list walk; req.ready stays
// low while a result cannot be placed in the output register.
// Reset clears all cells, the length and any pending result.
`include "indexed_insert_delete_list_top_assert.svh"

module indexed_insert_delete_list_top #(
  parameter int DEPTH       = 32,
  parameter int VALUE_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  idll_in_if.sink   req,
  idll_out_if.source rsp
);
  import idll_pkg::*;

  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic [VALUE_WIDTH-1:0] ins_val;
  logic signed [63:0]     ins_wide;
  logic signed [63:0]     head_wide;
  cell_cmd_t              cmd;

  state_t             state, state_next;
  logic [LEN_W-1:0]   length, length_next;
  logic [IDX_W-1:0]   cnt, cnt_next;
  logic               o_valid;
  status_t            o_status;
  logic [5:0]         o_slot;
  logic signed [31:0] o_data;
  logic               o_last;

  logic               acc, out_free, load, op_ok;
  status_t            ld_status;
  logic [5:0]         ld_slot;
  logic signed [31:0] ld_data;
  logic               ld_last;
  logic [CNT_W-1:0]   len_c, pos_c, nlen_c, cnt_c;

  assign ins_wide  = 64'(req.item_value);
  assign ins_val   = VALUE_WIDTH'(ins_wide);
  assign head_wide = 64'($signed(cell_val[0]));

  assign len_c  = CNT_W'(length);
  assign pos_c  = CNT_W'(req.position);
  assign nlen_c = CNT_W'(req.new_length);
  assign cnt_c  = CNT_W'(cnt);

  assign out_free  = !o_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign acc       = req.valid && req.ready;

  always_comb begin
    state_next  = state;
    length_next = length;
    cnt_next    = cnt;
    cmd.op      = CELL_HOLD;
    cmd.arg     = '0;
    load        = 1'b0;
    op_ok       = 1'b0;
    ld_status   = ST_OK;
    ld_slot     = req.position;
    ld_data     = '0;
    ld_last     = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          load = 1'b1;
          unique case (req.action)
            ACT_INSERT: begin
              if (pos_c > len_c) begin
                ld_status = ST_BAD_INDEX;
              end else if (len_c == DEPTH_C) begin
                ld_status = ST_FULL;
              end else begin
                op_ok       = 1'b1;
                cmd.op      = CELL_INSERT;
                cmd.arg     = pos_c;
                length_next = LEN_W'(len_c + 1'b1);
              end
            end
            ACT_DELETE: begin
              if (len_c == '0) begin
                ld_status = ST_EMPTY;
              end else if (pos_c >= len_c) begin
                ld_status = ST_BAD_INDEX;
              end else begin
                cmd.op      = CELL_DELETE;
                cmd.arg     = pos_c;
                length_next = LEN_W'(len_c - 1'b1);
              end
            end
            ACT_LIST: begin
              if (len_c == '0) begin
                ld_status = ST_EMPTY;
                ld_slot   = '0;
              end else begin
                load       = 1'b0;
                state_next = S_LIST;
                cnt_next   = '0;
              end
            end
            ACT_RESIZE: begin
              ld_slot = req.new_length;
              if (nlen_c == '0 || nlen_c > DEPTH_C) begin
                ld_status = ST_BAD_SIZE;
              end else begin
                cmd.op      = CELL_TRIM;
                cmd.arg     = nlen_c;
                length_next = LEN_W'(nlen_c);
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = ST_OK;
          ld_slot   = 6'(cnt);
          ld_data   = head_wide[31:0];
          ld_last   = (cnt_c == len_c - 1'b1);
          cmd.op    = CELL_ROTATE;
          cmd.arg   = len_c - 1'b1;
          cnt_next  = IDX_W'(cnt_c + 1'b1);
          if (ld_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      length  <= '0;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      cnt    <= cnt_next;
      if (load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_status <= ld_status;
      o_slot   <= ld_slot;
      o_data   <= ld_data;
      o_last   <= ld_last;
    end
  end

  assign rsp.valid  = o_valid;
  assign rsp.status = o_status;
  assign rsp.slot   = o_slot;
  assign rsp.data   = o_data;
  assign rsp.last   = o_last;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v;
    logic [VALUE_WIDTH-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    idll_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .ins_value   (ins_val),
      .left_value  (left_v),
      .right_value (right_v),
      .wrap_value  (cell_val[0]),
      .value       (cell_val[i])
    );
  end

  `IDLL_ASSERT_NOW(a_len_bound, 1'b1, len_c <= DEPTH_C)
  `IDLL_ASSERT_NOW(a_tail_zero, len_c < DEPTH_C, cell_val[DEPTH-1] == '0)
  `IDLL_ASSERT_NEXT(a_insert_grows, op_ok, len_c == $past(len_c) + 1'b1)
  `IDLL_ASSERT_NEXT(a_single_result, acc && req.action != ACT_LIST, o_valid && o_last)

endmodule
